// ----- design/dpdc_pkg.sv -----
package dpdc_pkg;

  localparam int TIME_WIDTH_DEF = 64;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W = 32;
  localparam int THR_W = 32;
  localparam int DB_W = 8;

  localparam logic [DB_W-1:0] DEBOUNCE_COUNT_RST = DB_W'(10);
  localparam logic [THR_W-1:0] HOLD_TIME_RST = THR_W'(500 * 1000);
  localparam logic [THR_W-1:0] LONG_HOLD_TIME_RST = THR_W'(2000 * 1000);
  localparam logic [THR_W-1:0] VLONG_HOLD_TIME_RST = THR_W'(5000 * 1000);

  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_COUNT = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_TIME = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_HOLD_TIME = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] CFG_VLONG_HOLD_TIME = CFG_INDEX_W'(3);

  typedef enum logic [3:0] {
    EV_NONE        = 4'd0,
    EV_DOWN        = 4'd1,
    EV_CLICK_REL   = 4'd2,
    EV_HOLD_BEGIN  = 4'd3,
    EV_HOLD_REL    = 4'd4,
    EV_LONG_BEGIN  = 4'd5,
    EV_LONG_REL    = 4'd6,
    EV_VLONG_BEGIN = 4'd7,
    EV_VLONG_REL   = 4'd8
  } event_t;

  typedef struct packed {
    logic [DB_W-1:0]  debounce_count;
    logic [THR_W-1:0] hold_time_us;
    logic [THR_W-1:0] long_hold_time_us;
    logic [THR_W-1:0] very_long_hold_time_us;
  } cfg_t;

endpackage

// ----- design/dpdc_tracker.sv -----
module dpdc_tracker
  import dpdc_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic                  raw,
  input  logic [TIME_WIDTH-1:0] now,
  input  cfg_t                  cfg,
  output event_t                event_code,
  output logic                  stable_level
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PRESSED,
    PH_HOLD,
    PH_LONG,
    PH_VLONG
  } phase_t;

  logic [DB_W-1:0]       cnt_r, cnt_nxt;
  logic                  level_r, level_nxt;
  phase_t                phase_r, phase_nxt;
  logic [TIME_WIDTH-1:0] start_r, start_nxt;
  event_t                event_r, event_nxt;
  logic [DB_W-1:0]       limit;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  over_hold, over_long, over_vlong;

  always_comb begin
    limit = (cfg.debounce_count == '0) ? DB_W'(1) : cfg.debounce_count;
    cnt_nxt = cnt_r;
    if (raw) begin
      if (cnt_r < limit) cnt_nxt = cnt_r + DB_W'(1);
    end else begin
      if (cnt_r != '0) cnt_nxt = cnt_r - DB_W'(1);
    end
    level_nxt = level_r;
    if (cnt_nxt >= limit) begin
      level_nxt = 1'b1;
    end else if (cnt_nxt == '0) begin
      level_nxt = 1'b0;
    end
  end

  assign elapsed    = now - start_r;
  assign over_hold  = elapsed > TIME_WIDTH'(cfg.hold_time_us);
  assign over_long  = elapsed > TIME_WIDTH'(cfg.long_hold_time_us);
  assign over_vlong = elapsed > TIME_WIDTH'(cfg.very_long_hold_time_us);

  always_comb begin
    phase_nxt = phase_r;
    start_nxt = start_r;
    event_nxt = EV_NONE;
    unique case (phase_r)
      PH_PRESSED: begin
        if (!level_nxt) begin
          phase_nxt = PH_IDLE;
          event_nxt = EV_CLICK_REL;
        end else if (over_long) begin
          phase_nxt = PH_LONG;
          event_nxt = EV_LONG_BEGIN;
        end else if (over_hold) begin
          phase_nxt = PH_HOLD;
          event_nxt = EV_HOLD_BEGIN;
        end
      end
      PH_HOLD: begin
        if (!level_nxt) begin
          phase_nxt = PH_IDLE;
          event_nxt = EV_HOLD_REL;
        end else if (over_long) begin
          phase_nxt = PH_LONG;
          event_nxt = EV_LONG_BEGIN;
        end
      end
      PH_LONG: begin
        if (!level_nxt) begin
          phase_nxt = PH_IDLE;
          event_nxt = EV_LONG_REL;
        end else if (over_vlong) begin
          phase_nxt = PH_VLONG;
          event_nxt = EV_VLONG_BEGIN;
        end
      end
      PH_VLONG: begin
        if (!level_nxt) begin
          phase_nxt = PH_IDLE;
          event_nxt = EV_VLONG_REL;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (level_nxt) begin
          phase_nxt = PH_PRESSED;
          start_nxt = now;
          event_nxt = EV_DOWN;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      level_r <= 1'b0;
      phase_r <= PH_IDLE;
      start_r <= '0;
      event_r <= EV_NONE;
    end else if (step) begin
      cnt_r   <= cnt_nxt;
      level_r <= level_nxt;
      phase_r <= phase_nxt;
      start_r <= start_nxt;
      event_r <= event_nxt;
    end
  end

  assign event_code   = event_r;
  assign stable_level = level_r;

endmodule

// ----- design/debounced_press_duration_classifier.sv -----
// An accepted beat waits in the input register, then steps into the result register.
// Throughput: one beat per cycle; the input register and the result register
// form a two-entry pipeline, so the input stalls only while a full pipeline
// waits on a stalled output.
// Reset (synchronous, active low) empties the pipeline, loads the default
// thresholds and returns the debouncer and the press tracker to released/idle.
module debounced_press_duration_classifier
  import dpdc_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_raw_pressed,
  input  logic [63:0]            in_now_us,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [3:0]             out_event_code,
  output logic                   out_stable_level,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t                  cfg_r;
  logic                  s1_valid_r;
  logic                  raw_r;
  logic [TIME_WIDTH-1:0] now_r;
  logic                  out_valid_r;
  logic                  out_load;
  logic                  step;
  logic                  in_take;
  event_t                event_code;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_count         <= DEBOUNCE_COUNT_RST;
      cfg_r.hold_time_us           <= HOLD_TIME_RST;
      cfg_r.long_hold_time_us      <= LONG_HOLD_TIME_RST;
      cfg_r.very_long_hold_time_us <= VLONG_HOLD_TIME_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEBOUNCE_COUNT:  cfg_r.debounce_count         <= cfg_data[DB_W-1:0];
        CFG_HOLD_TIME:       cfg_r.hold_time_us           <= cfg_data[THR_W-1:0];
        CFG_LONG_HOLD_TIME:  cfg_r.long_hold_time_us      <= cfg_data[THR_W-1:0];
        CFG_VLONG_HOLD_TIME: cfg_r.very_long_hold_time_us <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_load = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && out_load;
  assign in_stall = s1_valid_r && !out_load;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (step) begin
        s1_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      raw_r <= in_raw_pressed;
      now_r <= in_now_us[TIME_WIDTH-1:0];
    end
  end

  dpdc_tracker #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_tracker (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .raw          (raw_r),
    .now          (now_r),
    .cfg          (cfg_r),
    .event_code   (event_code),
    .stable_level (out_stable_level)
  );

  assign out_valid      = out_valid_r;
  assign out_event_code = event_code;

endmodule

// ----- design/dpdc_checker.sv -----
module dpdc_checker
  import dpdc_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] out_event_code,
  input logic       out_stable_level
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat offered right after reset");

  // Press and hold events only occur while the debounced level is pressed.
  a_press_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_code == EV_DOWN || out_event_code == EV_HOLD_BEGIN ||
                  out_event_code == EV_LONG_BEGIN || out_event_code == EV_VLONG_BEGIN)
    |-> out_stable_level)
    else $error("press event with released level");

  // Release events only occur once the debounced level has dropped.
  a_release_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_code == EV_CLICK_REL || out_event_code == EV_HOLD_REL ||
                  out_event_code == EV_LONG_REL || out_event_code == EV_VLONG_REL)
    |-> !out_stable_level)
    else $error("release event with pressed level");

endmodule

bind debounced_press_duration_classifier dpdc_checker u_dpdc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_event_code   (out_event_code),
  .out_stable_level (out_stable_level)
);

// ----- verif/debounced_press_duration_classifier_tb.sv -----
`timescale 1ns / 100ps

module debounced_press_duration_classifier_tb;
  import dpdc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_LIMIT = 500;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_FIRST = CFG_INDEX_W'(4);
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LAST = '1;

  typedef enum logic [2:0] {
    PRESS_IDLE, PRESS_DOWN, PRESS_HOLD, PRESS_LONG, PRESS_VLONG
  } press_state_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  typedef struct packed {
    logic        raw;
    logic [63:0] stamp;
  } poll_t;

  typedef struct packed {
    event_t code;
    logic   level;
  } poll_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_raw_pressed = 1'b0;
  logic [63:0]            in_now_us = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [3:0]             out_event_code;
  logic                   out_stable_level;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  cfg_t            live_cfg;
  logic [DB_W-1:0] db_counter = '0;
  logic            db_level = 1'b0;
  press_state_t    press_state = PRESS_IDLE;
  logic [63:0]     press_origin = '0;

  poll_t        pending_polls[$];
  poll_result_t expected_events[$];
  poll_t        next_poll;
  poll_result_t want;
  logic         holding_poll = 1'b0;
  logic [63:0]  clock_us = '0;
  int           burst_left = 0;
  int           gap_left = 0;
  stall_mode_t  stall_mode = STALL_NONE;
  int           stall_left = 0;
  int           mismatch_count = 0;
  int           idle_cycles = 0;
  int           guard = 0;

  debounced_press_duration_classifier u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_raw_pressed  (in_raw_pressed),
    .in_now_us       (in_now_us),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_code  (out_event_code),
    .out_stable_level(out_stable_level),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic poll_result_t classify_poll(input logic raw, input logic [63:0] stamp);
    logic [DB_W-1:0] limit;
    logic [63:0]     elapsed;
    poll_result_t    res;
    limit = (live_cfg.debounce_count == '0) ? DB_W'(1) : live_cfg.debounce_count;
    if (raw) begin
      if (db_counter < limit) db_counter = db_counter + 1'b1;
    end else if (db_counter != '0) begin
      db_counter = db_counter - 1'b1;
    end
    if (db_counter >= limit) db_level = 1'b1;
    else if (db_counter == '0) db_level = 1'b0;
    elapsed = stamp - press_origin;
    res.code = EV_NONE;
    case (press_state)
      PRESS_DOWN: begin
        if (!db_level) begin
          press_state = PRESS_IDLE;
          res.code = EV_CLICK_REL;
        end else if (elapsed > 64'(live_cfg.long_hold_time_us)) begin
          press_state = PRESS_LONG;
          res.code = EV_LONG_BEGIN;
        end else if (elapsed > 64'(live_cfg.hold_time_us)) begin
          press_state = PRESS_HOLD;
          res.code = EV_HOLD_BEGIN;
        end
      end
      PRESS_HOLD: begin
        if (!db_level) begin
          press_state = PRESS_IDLE;
          res.code = EV_HOLD_REL;
        end else if (elapsed > 64'(live_cfg.long_hold_time_us)) begin
          press_state = PRESS_LONG;
          res.code = EV_LONG_BEGIN;
        end
      end
      PRESS_LONG: begin
        if (!db_level) begin
          press_state = PRESS_IDLE;
          res.code = EV_LONG_REL;
        end else if (elapsed > 64'(live_cfg.very_long_hold_time_us)) begin
          press_state = PRESS_VLONG;
          res.code = EV_VLONG_BEGIN;
        end
      end
      PRESS_VLONG: begin
        if (!db_level) begin
          press_state = PRESS_IDLE;
          res.code = EV_VLONG_REL;
        end
      end
      default: begin
        if (db_level) begin
          press_state = PRESS_DOWN;
          press_origin = stamp;
          res.code = EV_DOWN;
        end
      end
    endcase
    res.level = db_level;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic add_poll(input logic raw, input logic [63:0] stamp);
    poll_t p;
    p.raw = raw;
    p.stamp = stamp;
    pending_polls.push_back(p);
  endtask

  task automatic step_poll(input logic raw, input logic [63:0] step_max);
    clock_us = clock_us + rand64() % (step_max + 64'd1);
    add_poll(raw, clock_us);
  endtask

  task automatic random_phase(input int n_items);
    int          added;
    int          limit_n;
    int          n_on;
    int          n_off;
    int          bounce;
    logic [63:0] top;
    logic [63:0] step_max;
    added = 0;
    while (added < n_items) begin
      case ($urandom_range(0, 11))
        0: begin
          add_poll(1'($urandom_range(0, 1)), rand64());
          added++;
        end
        1: clock_us = rand64();
        default: begin
          limit_n = (live_cfg.debounce_count == '0) ? 1 : int'(live_cfg.debounce_count);
          n_on = ($urandom_range(0, 4) == 0) ? $urandom_range(1, limit_n)
                                              : limit_n + $urandom_range(0, 12);
          n_off = ($urandom_range(0, 4) == 0) ? $urandom_range(1, limit_n)
                                               : limit_n + $urandom_range(0, 4);
          top = 64'(live_cfg.hold_time_us);
          if (64'(live_cfg.long_hold_time_us) > top) top = 64'(live_cfg.long_hold_time_us);
          if (64'(live_cfg.very_long_hold_time_us) > top) begin
            top = 64'(live_cfg.very_long_hold_time_us);
          end
          step_max = ($urandom_range(0, 4) == 0) ? 64'd3 : (top + top / 2) / 64'(n_on) + 64'd1;
          bounce = $urandom_range(0, 15);
          repeat (n_on) step_poll($urandom_range(0, 99) >= bounce, step_max);
          repeat (n_off) step_poll($urandom_range(0, 99) < bounce, step_max);
          added += n_on + n_off;
        end
      endcase
    end
  endtask

  task automatic drain();
    while (pending_polls.size() != 0 || holding_poll || expected_events.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_DEBOUNCE_COUNT: live_cfg.debounce_count = data[DB_W-1:0];
      CFG_HOLD_TIME: live_cfg.hold_time_us = data;
      CFG_LONG_HOLD_TIME: live_cfg.long_hold_time_us = data;
      CFG_VLONG_HOLD_TIME: live_cfg.very_long_hold_time_us = data;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] count_word,
                           input logic [CFG_DATA_W-1:0] hold_thr,
                           input logic [CFG_DATA_W-1:0] long_thr,
                           input logic [CFG_DATA_W-1:0] vlong_thr);
    if ($urandom_range(0, 1) == 0) cfg_write(CFG_SPARE_FIRST, $urandom);
    cfg_write(CFG_DEBOUNCE_COUNT, count_word);
    cfg_write(CFG_HOLD_TIME, hold_thr);
    cfg_write(CFG_LONG_HOLD_TIME, long_thr);
    cfg_write(CFG_VLONG_HOLD_TIME, vlong_thr);
    if ($urandom_range(0, 1) == 0) cfg_write(CFG_SPARE_LAST, $urandom);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        expected_events.push_back(classify_poll(in_raw_pressed, in_now_us));
        holding_poll = 1'b0;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_polls.size() != 0) begin
        next_poll = pending_polls.pop_front();
        holding_poll = 1'b1;
        in_valid <= 1'b1;
        in_raw_pressed <= next_poll.raw;
        in_now_us <= next_poll.stamp;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 60);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_left = $urandom_range(8, 80);
      end
      stall_left--;
      case (stall_mode)
        STALL_NONE: out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (stall_left % 8 < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("unexpected beat: event %0d level %0b",
                                  out_event_code, out_stable_level));
      end else begin
        want = expected_events.pop_front();
        if (out_event_code !== want.code) begin
          report_mismatch($sformatf("event_code %0d, expected %0d (%s)",
                                    out_event_code, want.code, want.code.name()));
        end
        if (out_stable_level !== want.level) begin
          report_mismatch($sformatf("stable_level %0b, expected %0b",
                                    out_stable_level, want.level));
        end
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("[%0t] timeout: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("FAIL debounced_press_duration_classifier");
    $finish;
  end

  initial begin
    live_cfg.debounce_count = DEBOUNCE_COUNT_RST;
    live_cfg.hold_time_us = HOLD_TIME_RST;
    live_cfg.long_hold_time_us = LONG_HOLD_TIME_RST;
    live_cfg.very_long_hold_time_us = VLONG_HOLD_TIME_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    clock_us = rand64();
    random_phase(110);
    repeat (10) step_poll(1'b0, 64'd1000);
    drain();

    // Exact threshold edges, every event, a direct jump to long hold and a time wrap.
    configure(32'd1, 32'd100, 32'd200, 32'd300);
    add_poll(1'b1, 64'd1000);
    add_poll(1'b1, 64'd1100);
    add_poll(1'b1, 64'd1101);
    add_poll(1'b1, 64'd1200);
    add_poll(1'b1, 64'd1201);
    add_poll(1'b1, 64'd1300);
    add_poll(1'b1, 64'd1301);
    add_poll(1'b1, 64'd1400);
    add_poll(1'b0, 64'd1401);
    add_poll(1'b0, 64'd1402);
    add_poll(1'b1, 64'd2000);
    add_poll(1'b0, 64'd2001);
    add_poll(1'b1, 64'd3000);
    add_poll(1'b1, 64'd3150);
    add_poll(1'b0, 64'd3151);
    add_poll(1'b1, 64'd4000);
    add_poll(1'b1, 64'd4201);
    add_poll(1'b0, 64'd4202);
    add_poll(1'b1, 64'hFFFF_FFFF_FFFF_FFCE);
    add_poll(1'b1, 64'd49);
    add_poll(1'b1, 64'd51);
    add_poll(1'b0, 64'd52);
    add_poll(1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    add_poll(1'b0, 64'd0);
    drain();

    configure(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
    random_phase(90);
    drain();

    configure(32'hFFFF_FF03, 32'd3000000, 32'd1000000, 32'd500000);
    random_phase(110);
    drain();

    configure(32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_phase(90);
    drain();

    // The count is lowered while the counter sits well above the new value.
    configure(32'd255, 32'd5000, 32'd20000, 32'd50000);
    repeat (4) step_poll(1'b0, 64'd1000);
    repeat (20) step_poll(1'b1, 64'd1000);
    repeat (5) step_poll(1'b0, 64'd1000);
    repeat (15) step_poll(1'b1, 64'd1000);
    drain();
    cfg_write(CFG_DEBOUNCE_COUNT, 32'd4);
    cfg_valid <= 1'b0;
    repeat (6) step_poll(1'b1, 64'd4000);
    repeat (34) step_poll(1'b0, 64'd4000);
    random_phase(40);
    drain();

    configure(32'd5, $urandom_range(0, 2000), $urandom_range(0, 4000), $urandom_range(0, 8000));
    random_phase(110);
    drain();

    configure({24'($urandom), 8'($urandom_range(1, 8))}, $urandom, $urandom, $urandom);
    random_phase(100);

    while (pending_polls.size() != 0 || holding_poll) @(posedge clk);
    while (expected_events.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_events.size() != 0) begin
      report_mismatch($sformatf("%0d expected beats never arrived", expected_events.size()));
    end
    if (mismatch_count == 0) begin
      $display("PASS debounced_press_duration_classifier");
    end else begin
      $display("FAIL debounced_press_duration_classifier");
    end
    $finish;
  end

endmodule
